>>> sv/fsp_pkg.sv
// fsp_pkg: shared constants, codes and rounding helper for the float sample packer
// no dependencies
package fsp_pkg;

  localparam logic [1:0] FMT_UNORM  = 2'd0;
  localparam logic [1:0] FMT_HALF   = 2'd1;
  localparam logic [1:0] FMT_SINGLE = 2'd2;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_BITS   = 2'd1;
  localparam logic [1:0] REG_ENDIAN = 2'd2;

  localparam int PROD_W = 40;
  localparam logic [6:0] SH_LIMIT = 7'd41;

  localparam logic [2:0] BYTES_ONE  = 3'd1;
  localparam logic [2:0] BYTES_TWO  = 3'd2;
  localparam logic [2:0] BYTES_FOUR = 3'd4;

  // shift right, round to nearest, ties to even
  function automatic logic [PROD_W-1:0] shift_rne(input logic [PROD_W-1:0] x,
                                                  input logic [6:0] sh);
    logic [PROD_W:0] xe;
    logic [PROD_W:0] q;
    logic [PROD_W:0] rem;
    logic [PROD_W:0] half;
    xe = {1'b0, x};
    q = xe >> sh;
    rem = xe & (({{PROD_W{1'b0}}, 1'b1} << sh) - 1'b1);
    half = {{PROD_W{1'b0}}, 1'b1} << (sh - 7'd1);
    if (rem > half || (rem == half && q[0])) begin
      q = q + 1'b1;
    end
    if (sh == 7'd0) begin
      shift_rne = x;
    end else if (sh >= SH_LIMIT) begin
      shift_rne = '0;
    end else begin
      shift_rne = q[PROD_W-1:0];
    end
  endfunction

endpackage

>>> sv/fsp_unorm_conv.sv
// fsp_unorm_conv: rounds a scaled binary32 mantissa product to an unsigned integer
// depends on fsp_pkg
module fsp_unorm_conv import fsp_pkg::*; (
  input  logic [31:0]       sample,
  input  logic [PROD_W-1:0] prod,
  input  logic [4:0]        bits,
  output logic [15:0]       value
);

  logic [7:0]        ex;
  logic [22:0]       man;
  logic [15:0]       mul;
  logic [PROD_W-1:0] top;
  logic [4:0]        s;
  logic [PROD_W-1:0] q;
  logic [PROD_W-1:0] r;
  logic [7:0]        sh2;

  assign ex  = sample[30:23];
  assign man = sample[22:0];
  assign mul = 16'(({{16{1'b0}}, 1'b1} << bits) - 17'd1);
  assign top = prod >> (6'd23 + {1'b0, bits});
  // product has bit length 23+bits or 24+bits
  assign s   = top[0] ? bits : bits - 5'd1;
  assign q   = shift_rne(prod, {2'b0, s});
  assign sh2 = 8'd150 - ex - {3'b0, s};
  // shifts of 128 and more flush to zero like any shift past the limit
  assign r   = shift_rne(q, sh2[7] ? 7'h7f : sh2[6:0]);

  always_comb begin
    if (ex == 8'hff && man != '0) begin
      value = '0;
    end else if (sample[31]) begin
      value = '0;
    end else if (ex == 8'd0) begin
      value = '0;
    end else if (ex >= 8'd127) begin
      value = mul;
    end else begin
      value = r[15:0];
    end
  end

endmodule

>>> sv/fsp_half_conv.sv
// fsp_half_conv: binary32 to binary16 demotion, nearest-even
// depends on fsp_pkg
module fsp_half_conv import fsp_pkg::*; (
  input  logic [31:0] sample,
  output logic [15:0] value
);

  logic [15:0]       sign;
  logic [7:0]        ex;
  logic [22:0]       man;
  logic [PROD_W-1:0] rn;
  logic [PROD_W-1:0] rs;
  logic [7:0]        sub_sh;

  assign sign   = {sample[31], 15'b0};
  assign ex     = sample[30:23];
  assign man    = sample[22:0];
  assign rn     = shift_rne({17'b0, man}, 7'd13);
  // shift for subnormal result is 126 - ex
  assign sub_sh = 8'd126 - ex;
  assign rs     = shift_rne({16'b0, 1'b1, man}, (sub_sh > 8'd64) ? 7'd64 : sub_sh[6:0]);

  always_comb begin
    if (ex == 8'hff) begin
      if (man == '0) value = sign | 16'h7c00;
      else value = sign | 16'h7e00 | {6'b0, man[22:13]};
    end else if (ex == 8'd0) begin
      value = sign;
    end else if (ex > 8'd142) begin
      value = sign | 16'h7c00;
    end else if (ex >= 8'd113) begin
      value = sign + {1'b0, 5'(ex - 8'd112), 10'b0} + rn[15:0];
    end else begin
      value = sign | rs[15:0];
    end
  end

endmodule

>>> sv/float_sample_packer_unit.sv
// float_sample_packer_unit: packs one binary32 sample per transfer into 1, 2 or 4 bytes
// depends on fsp_pkg, fsp_unorm_conv, fsp_half_conv
// path: input register, then result register; a low out_ready holds the result and,
//   once the input register is full, also the input
// throughput: one sample per cycle unless stalled; mantissa multiplier before input reg
// reset: synchronous, active high; clears both stage valids and loads format 0,
//   width 8 and little-endian order
module float_sample_packer_unit import fsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_bits,
  input  logic        end_of_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_bytes,
  output logic [2:0]  byte_count,
  output logic        row_end_flag,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [1:0] output_format;
  logic [4:0] sample_bits_used;
  logic       little_endian_order;

  // input stage
  logic              s1_valid;
  logic [31:0]       s1_sample;
  logic              s1_eor;
  logic [PROD_W-1:0] s1_prod;

  logic [4:0]        bits;
  logic [15:0]       mul;
  logic [PROD_W-1:0] prod_next;
  logic              s1_adv;
  logic              out_load;

  logic [15:0] unorm_val;
  logic [15:0] half_val;
  logic [31:0] bytes_next;
  logic [2:0]  count_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_format       <= FMT_UNORM;
      sample_bits_used    <= 5'd8;
      little_endian_order <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FORMAT: output_format       <= cfg_data[1:0];
        REG_BITS:   sample_bits_used    <= cfg_data[4:0];
        REG_ENDIAN: little_endian_order <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // width clamped to 1..16
  always_comb begin
    if (sample_bits_used == 5'd0) bits = 5'd1;
    else if (sample_bits_used > 5'd16) bits = 5'd16;
    else bits = sample_bits_used;
  end

  assign mul       = 16'(({{16{1'b0}}, 1'b1} << bits) - 17'd1);
  assign prod_next = {16'b0, 1'b1, sample_bits[22:0]} * {24'b0, mul};

  // pipeline flow
  assign out_load = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_load;
  assign in_ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= sample_bits;
      s1_eor    <= end_of_row;
      s1_prod   <= prod_next;
    end
  end

  fsp_unorm_conv u_unorm (
    .sample (s1_sample),
    .prod   (s1_prod),
    .bits   (bits),
    .value  (unorm_val)
  );

  fsp_half_conv u_half (
    .sample (s1_sample),
    .value  (half_val)
  );

  // byte ordering per mode
  always_comb begin
    case (output_format)
      FMT_UNORM: begin
        if (bits <= 5'd8) begin
          count_next = BYTES_ONE;
          bytes_next = {24'b0, unorm_val[7:0]};
        end else begin
          count_next = BYTES_TWO;
          bytes_next = little_endian_order ? {16'b0, unorm_val}
                                           : {16'b0, unorm_val[7:0], unorm_val[15:8]};
        end
      end
      FMT_HALF: begin
        count_next = BYTES_TWO;
        bytes_next = little_endian_order ? {16'b0, half_val}
                                         : {16'b0, half_val[7:0], half_val[15:8]};
      end
      default: begin
        // single float, and the unused fourth code
        count_next = BYTES_FOUR;
        bytes_next = little_endian_order ? s1_sample
                     : {s1_sample[7:0], s1_sample[15:8], s1_sample[23:16], s1_sample[31:24]};
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_bytes    <= bytes_next;
      byte_count   <= count_next;
      row_end_flag <= s1_eor;
    end
  end

endmodule
